// ----- design/e2q_pkg.sv -----
// Package for the Euler-angle to quaternion converter.
// Holds fixed-point constants, widths and helper functions. No dependencies.
package e2q_pkg;

   localparam int AngleWidth = 16;
   localparam int QuatWidth  = 16;
   localparam int QWidth     = 32;   // signed Q30 working value
   localparam int PhaseWidth = 16;   // 0..46079
   localparam int RemWidth   = 14;   // 0..11519
   localparam int XWidth     = 31;   // x below pi/2 in Q30

   localparam logic [16:0] TurnRaw   = 17'd46080;
   localparam logic [13:0] QuadRaw   = 14'd11520;
   localparam logic [30:0] QOne      = 31'h4000_0000;

   // Pi/2 in Q30 is XBase * QuadRaw + XFrac, so r * pi/2 / QuadRaw splits into
   // r * XBase plus a small quotient. QuadRaw is 256 * 45, and XFracRecip is
   // the reciprocal of 45 scaled by 2^26, exact for the quotients that occur.
   localparam logic [17:0] XBase      = 18'd146408;
   localparam logic [13:0] XFrac      = 14'd9553;
   localparam logic [20:0] XFracRecip = 21'd1491309;

   localparam int SinSteps = 5;
   localparam int CosSteps = 6;

   // Register stages in one sine and cosine unit.
   localparam int SinCosDepth = 18;

   typedef logic signed [QWidth-1:0] q30_type;

   // Horner divisors, sine and cosine series.
   function automatic logic [7:0] sin_div(input int idx);
      logic [7:0] d;
      case (idx)
         0: d = 8'd110;
         1: d = 8'd72;
         2: d = 8'd42;
         3: d = 8'd20;
         default: d = 8'd6;
      endcase
      return d;
   endfunction

   function automatic logic [7:0] cos_div(input int idx);
      logic [7:0] d;
      case (idx)
         0: d = 8'd132;
         1: d = 8'd90;
         2: d = 8'd56;
         3: d = 8'd30;
         4: d = 8'd12;
         default: d = 8'd2;
      endcase
      return d;
   endfunction

   // Rounded-up reciprocal of a series divisor, scaled by 2^div_shift.
   // The product with any 32-bit value, shifted down, gives the exact floor.
   function automatic logic [32:0] div_recip(input logic [7:0] d);
      logic [32:0] m;
      case (d)
         8'd132: m = 33'd8329633544;
         8'd110: m = 33'd4997780127;
         8'd90:  m = 33'd6108397933;
         8'd72:  m = 33'd7635497416;
         8'd56:  m = 33'd4908534053;
         8'd42:  m = 33'd6544712071;
         8'd30:  m = 33'd4581298450;
         8'd20:  m = 33'd6871947674;
         8'd12:  m = 33'd5726623062;
         8'd6:   m = 33'd5726623062;
         default: m = 33'd4294967296;
      endcase
      return m;
   endfunction

   function automatic int div_shift(input logic [7:0] d);
      int s;
      case (d)
         8'd132: s = 40;
         8'd110: s = 39;
         8'd90:  s = 39;
         8'd72:  s = 39;
         8'd56:  s = 38;
         8'd42:  s = 38;
         8'd30:  s = 37;
         8'd20:  s = 37;
         8'd12:  s = 36;
         8'd6:   s = 35;
         default: s = 33;
      endcase
      return s;
   endfunction

   // Signed Q30 by Q30 product rounded back to Q30, magnitude rounded half up.
   function automatic q30_type mul30(input q30_type a, input q30_type b);
      logic [30:0] ma;
      logic [30:0] mb;
      logic [61:0] p;
      logic [31:0] m;
      ma = a[31] ? 31'(-a) : a[30:0];
      mb = b[31] ? 31'(-b) : b[30:0];
      p  = 62'(ma) * 62'(mb) + 62'h2000_0000;
      m  = p[61:30];
      return (a[31] ^ b[31]) ? q30_type'(-m) : q30_type'(m);
   endfunction

   // Q30 sum to saturated Q1.15, magnitude rounded half up.
   function automatic logic [QuatWidth-1:0] to_q15(input logic signed [33:0] v);
      logic [33:0] m;
      logic [18:0] r;
      logic signed [19:0] s;
      m = v[33] ? 34'(-v) : 34'(v);
      r = 19'((m + 34'h4000) >> 15);
      s = v[33] ? -20'(signed'({1'b0, r})) : 20'(signed'({1'b0, r}));
      if (s > 20'sd32767) return 16'h7fff;
      else if (s < -20'sd32768) return 16'h8000;
      else return s[15:0];
   endfunction

endpackage

// ----- design/e2q_stream_if.sv -----
// Valid/ready channel carrying one word of a generic payload type.
// Depends on nothing; payload type is given at instantiation.
interface e2q_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- design/e2q_sincos.sv -----
// Pipelined half-angle sine and cosine of one Q9.6 degree angle, in Q30.
// Depends on e2q_pkg. Advances when en is high.
module e2q_sincos import e2q_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic [AngleWidth-1:0] angle,
   output q30_type               sin_q,
   output q30_type               cos_q
);
   localparam int HStages = 2 * CosSteps;

   // Stage 1: reduce angle modulo one turn.
   logic signed [16:0] a_s;
   logic [16:0]        p_w;
   logic [PhaseWidth-1:0] p_ff;
   assign a_s = 17'(signed'(angle));
   assign p_w = a_s[16] ? 17'(a_s + signed'(TurnRaw)) : 17'(a_s);
   always_ff @(posedge clock) begin
      if (en) p_ff <= p_w[PhaseWidth-1:0];
   end

   // Stage 2: quadrant and remainder.
   logic [1:0] q_ff;
   logic [RemWidth-1:0] r_ff;
   logic [15:0] r0, r1, r2;
   assign r0 = p_ff;
   assign r1 = (r0 >= 16'(2*QuadRaw)) ? 16'(r0 - 16'(2*QuadRaw)) : r0;
   assign r2 = (r1 >= 16'(QuadRaw)) ? 16'(r1 - 16'(QuadRaw)) : r1;
   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= {p_ff >= 16'(2*QuadRaw), r1 >= 16'(QuadRaw)};
         r_ff <= r2[RemWidth-1:0];
      end
   end

   // Stage 3: remainder times the whole and the fractional part of pi/2 per step.
   logic [XWidth-1:0] xb_ff;
   logic [26:0] xf_ff;
   logic [1:0] q3_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         xb_ff <= XWidth'(r_ff) * XWidth'(XBase);
         xf_ff <= 27'(r_ff) * 27'(XFrac);
         q3_ff <= q_ff;
      end
   end

   // Stage 4: floor of the fractional part over the quadrant size, by a shift
   // and a reciprocal multiplication, added to the whole part.
   logic [39:0] xq;
   logic [XWidth-1:0] x_ff;
   logic [1:0] q4_ff;
   assign xq = 40'(xf_ff[26:8]) * 40'(XFracRecip);
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= xb_ff + XWidth'(xq[39:26]);
         q4_ff <= q3_ff;
      end
   end

   // Stage 5: square, which can reach 2.5 in Q30.
   logic [61:0] xx;
   logic [31:0] x2_ff;
   logic [XWidth-1:0] x5_ff;
   logic [1:0] q5_ff;
   assign xx = 62'(x_ff) * 62'(x_ff) + 62'h2000_0000;
   always_ff @(posedge clock) begin
      if (en) begin
         x2_ff <= xx[61:30];
         x5_ff <= x_ff;
         q5_ff <= q4_ff;
      end
   end

   // Truncated Q30 product of two series terms.
   function automatic logic [31:0] qmul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      return p[61:30];
   endfunction

   // One Horner update: t = 1 - n / d, clamped at zero.
   function automatic logic [31:0] hstep(input logic [31:0] n, input logic [7:0] d);
      logic [64:0] p;
      logic [31:0] m;
      p = 65'(n) * 65'(div_recip(d));
      m = 32'(p >> div_shift(d));
      return (m >= 32'(QOne)) ? 32'd0 : 32'(32'(QOne) - m);
   endfunction

   // Stages 6 to 17: each series step takes two stages, a truncated product
   // and then the division by its constant. The first product is with 1.0,
   // so it is the square itself. The sine series has one step fewer, and its
   // final product with x takes the slot of the last step.
   logic [31:0]       hx2_ff [HStages];
   logic [XWidth-1:0] hx_ff  [HStages];
   logic [1:0]        hq_ff  [HStages];
   logic [31:0]       hs_ff  [HStages];
   logic [31:0]       hc_ff  [HStages];
   always_ff @(posedge clock) begin
      if (en) begin
         hx2_ff[0] <= x2_ff;
         hx_ff[0]  <= x5_ff;
         hq_ff[0]  <= q5_ff;
         hs_ff[0]  <= x2_ff;
         hc_ff[0]  <= x2_ff;
         for (int j = 1; j < HStages; j++) begin
            hx2_ff[j] <= hx2_ff[j-1];
            hx_ff[j]  <= hx_ff[j-1];
            hq_ff[j]  <= hq_ff[j-1];
            if (j % 2 == 1) begin
               hc_ff[j] <= hstep(hc_ff[j-1], cos_div(j / 2));
               hs_ff[j] <= (j / 2 < SinSteps) ? hstep(hs_ff[j-1], sin_div(j / 2))
                                              : hs_ff[j-1];
            end else begin
               hc_ff[j] <= qmul(hx2_ff[j-1], hc_ff[j-1]);
               hs_ff[j] <= (j / 2 < SinSteps) ? qmul(hx2_ff[j-1], hs_ff[j-1])
                                              : qmul({1'b0, hx_ff[j-1]}, hs_ff[j-1]);
            end
         end
      end
   end

   // Stage 18: quadrant fold.
   q30_type s_ff, c_ff;
   q30_type s_v, c_v;
   assign s_v = q30_type'(hs_ff[HStages-1]);
   assign c_v = q30_type'(hc_ff[HStages-1]);
   always_ff @(posedge clock) begin
      if (en) begin
         case (hq_ff[HStages-1])
            2'd0: begin s_ff <= s_v;  c_ff <= c_v;  end
            2'd1: begin s_ff <= c_v;  c_ff <= -s_v; end
            2'd2: begin s_ff <= -s_v; c_ff <= -c_v; end
            default: begin s_ff <= -c_v; c_ff <= s_v; end
         endcase
      end
   end
   assign sin_q = s_ff;
   assign cos_q = c_ff;
endmodule

// ----- design/euler_to_quaternion.sv -----
// Euler angles (ZYX) to unit quaternion, fully pipelined.
// Throughput one word per cycle while the output is not stalled.
// The whole pipeline advances when its output register is empty or being taken.
// Reset (synchronous) clears the valid bits only; data registers are not reset.
// Depends on e2q_pkg, e2q_stream_if and e2q_sincos.
module euler_to_quaternion import e2q_pkg::*; (
   input logic clock,
   input logic reset,
   e2q_stream_if.sink   req,
   e2q_stream_if.source rsp
);
   localparam int Depth = SinCosDepth + 4;

   logic en;
   logic [Depth-1:0] vld_ff;
   assign en        = !vld_ff[Depth-1] || rsp.ready;
   assign req.ready = en;

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[Depth-2:0], req.valid};
   end

   q30_type sr, cr, sp, cp, sy, cy;
   e2q_sincos u_roll  (.clock, .en, .angle(req.data.roll_deg),  .sin_q(sr), .cos_q(cr));
   e2q_sincos u_pitch (.clock, .en, .angle(req.data.pitch_deg), .sin_q(sp), .cos_q(cp));
   e2q_sincos u_yaw   (.clock, .en, .angle(req.data.yaw_deg),   .sin_q(sy), .cos_q(cy));

   // Stage: pair products of yaw and pitch.
   q30_type cycp_ff, sysp_ff, sycp_ff, cysp_ff, sr_ff, cr_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         cycp_ff <= mul30(cy, cp);
         sysp_ff <= mul30(sy, sp);
         sycp_ff <= mul30(sy, cp);
         cysp_ff <= mul30(cy, sp);
         sr_ff <= sr; cr_ff <= cr;
      end
   end

   // Stage: triple products.
   q30_type t_ff [8];
   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[0] <= mul30(cycp_ff, cr_ff);
         t_ff[1] <= mul30(sysp_ff, sr_ff);
         t_ff[2] <= mul30(cycp_ff, sr_ff);
         t_ff[3] <= mul30(sysp_ff, cr_ff);
         t_ff[4] <= mul30(sycp_ff, sr_ff);
         t_ff[5] <= mul30(cysp_ff, cr_ff);
         t_ff[6] <= mul30(sycp_ff, cr_ff);
         t_ff[7] <= mul30(cysp_ff, sr_ff);
      end
   end

   // Stage: sums.
   logic signed [33:0] w_ff, x_ff, y_ff, z_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= 34'(t_ff[0]) + 34'(t_ff[1]);
         x_ff <= 34'(t_ff[2]) - 34'(t_ff[3]);
         y_ff <= 34'(t_ff[4]) + 34'(t_ff[5]);
         z_ff <= 34'(t_ff[6]) - 34'(t_ff[7]);
      end
   end

   // Output register: rounding and saturation.
   always_ff @(posedge clock) begin
      if (en) begin
         rsp.data.quat_w <= to_q15(w_ff);
         rsp.data.quat_x <= to_q15(x_ff);
         rsp.data.quat_y <= to_q15(y_ff);
         rsp.data.quat_z <= to_q15(z_ff);
      end
   end
   assign rsp.valid = vld_ff[Depth-1];

   // A stalled result word holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result word changed under stall");
   // Input is taken whenever the output is free.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("pipeline stalled with empty output");
endmodule
